// ----- hw/rtl/acc_pkg.sv -----
// Shared types and constants for the accumulator core: result kinds,
// datapath command/status structs and their encodings. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam logic [15:0] TIMER_RESET = 16'd100;

  // Result kinds on the out channel
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_PUTI  = 3'd2;
  localparam logic [2:0] KIND_PUTC  = 3'd3;
  localparam logic [2:0] KIND_BADP  = 3'd4;
  localparam logic [2:0] KIND_HALT  = 3'd5;
  localparam logic [2:0] KIND_VIOL  = 3'd6;

  // Register update applied by the datapath
  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LD_IR, OP_LD_AC, OP_LD_PC, OP_LD_SP_USR, OP_PC_INC,
    OP_TMR, OP_TICK, OP_HALT, OP_GET, OP_ADDX, OP_ADDY, OP_SUBX, OP_SUBY,
    OP_AC2X, OP_X2AC, OP_AC2Y, OP_Y2AC, OP_AC2SP, OP_SP2AC, OP_INCX, OP_DECX
  } dp_op_t;

  // Address source of an emitted beat
  typedef enum logic [3:0] {
    A_ZERO, A_PC, A_SP, A_SP_DEC, A_SP_X, A_DIN, A_DIN_X, A_DIN_Y, A_INT1, A_INT2
  } asel_t;

  // Data source of an emitted beat
  typedef enum logic [2:0] {
    D_ZERO, D_AC, D_AC8, D_DIN, D_SP, D_PC, D_PC1
  } dsel_t;

  // Side effect taken with an emitted beat
  typedef enum logic [2:0] {
    SE_NONE, SE_PC_INC, SE_SP_INC, SE_SP_DEC, SE_INT1, SE_INT2_TMR, SE_INT2_SW
  } se_t;

  typedef struct packed {
    logic       capture;
    dp_op_t     op;
    logic       emit;
    logic [2:0] kind;
    logic       check;
    asel_t      asel;
    dsel_t      dsel;
    se_t        se;
  } acc_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       viol;
    logic       ac_zero;
    logic       din_is1;
    logic       din_is2;
    logic       kernel;
    logic       pend;
    logic       ir_small;
    logic [5:0] ir_op;
  } acc_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/acc_ctrl.sv -----
// Sequencer of the accumulator core: phase tracking, opcode decode and
// the order of emitted beats. Depends on acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  output logic                   in_ready,
  input  wire acc_pkg::acc_stat_t stat,
  output acc_pkg::acc_cmd_t      cmd
);

  localparam logic [5:0] OPC_LDV  = 6'd1;
  localparam logic [5:0] OPC_LDA  = 6'd2;
  localparam logic [5:0] OPC_LDI  = 6'd3;
  localparam logic [5:0] OPC_LDX  = 6'd4;
  localparam logic [5:0] OPC_LDY  = 6'd5;
  localparam logic [5:0] OPC_LDSX = 6'd6;
  localparam logic [5:0] OPC_ST   = 6'd7;
  localparam logic [5:0] OPC_GET  = 6'd8;
  localparam logic [5:0] OPC_PUT  = 6'd9;
  localparam logic [5:0] OPC_ADDX = 6'd10;
  localparam logic [5:0] OPC_ADDY = 6'd11;
  localparam logic [5:0] OPC_SUBX = 6'd12;
  localparam logic [5:0] OPC_SUBY = 6'd13;
  localparam logic [5:0] OPC_TOX  = 6'd14;
  localparam logic [5:0] OPC_FRX  = 6'd15;
  localparam logic [5:0] OPC_TOY  = 6'd16;
  localparam logic [5:0] OPC_FRY  = 6'd17;
  localparam logic [5:0] OPC_TOSP = 6'd18;
  localparam logic [5:0] OPC_FRSP = 6'd19;
  localparam logic [5:0] OPC_JMP  = 6'd20;
  localparam logic [5:0] OPC_JEQ  = 6'd21;
  localparam logic [5:0] OPC_JNE  = 6'd22;
  localparam logic [5:0] OPC_CALL = 6'd23;
  localparam logic [5:0] OPC_RET  = 6'd24;
  localparam logic [5:0] OPC_INCX = 6'd25;
  localparam logic [5:0] OPC_DECX = 6'd26;
  localparam logic [5:0] OPC_PUSH = 6'd27;
  localparam logic [5:0] OPC_POP  = 6'd28;
  localparam logic [5:0] OPC_INT  = 6'd29;
  localparam logic [5:0] OPC_IRET = 6'd30;
  localparam logic [5:0] OPC_END  = 6'd50;

  typedef enum logic [3:0] {
    S_WAIT, S_DISP, S_INIT, S_TMR, S_FCHK, S_INT1, S_INT2, S_FRD, S_FIN,
    S_LDIR, S_EXEC, S_ARG, S_RDARG
  } st_t;

  // What the next input beat carries
  typedef enum logic [3:0] {
    PH_IDLE, PH_FETCH, PH_ARG, PH_IND, PH_LOADAC, PH_RETPC, PH_IRETPC,
    PH_IRETSP, PH_POPAC, PH_HALT
  } phase_t;

  st_t    state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   act_r, act_nxt;
  logic   sw_r, sw_nxt;
  logic   go;

  assign in_ready = (state_r == S_WAIT);
  assign go       = stat.out_free;

  always_comb begin
    cmd         = '0;
    cmd.op      = acc_pkg::OP_NONE;
    cmd.asel    = acc_pkg::A_ZERO;
    cmd.dsel    = acc_pkg::D_ZERO;
    cmd.se      = acc_pkg::SE_NONE;
    cmd.kind    = acc_pkg::KIND_READ;
    cmd.capture = in_valid && in_ready;
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    act_nxt     = act_r;
    sw_nxt      = sw_r;

    case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          act_nxt   = in_action;
          state_nxt = S_DISP;
        end
      end

      // dispatch on what the returned word was for
      S_DISP: begin
        if (!act_r) begin
          state_nxt = S_INIT;
        end else begin
          case (phase_r)
            PH_FETCH: state_nxt = S_LDIR;
            PH_ARG:   state_nxt = S_ARG;
            PH_IND: begin
              cmd.emit  = go;
              cmd.kind  = acc_pkg::KIND_READ;
              cmd.check = 1'b1;
              cmd.asel  = acc_pkg::A_DIN;
              if (go) begin
                state_nxt = S_WAIT;
                phase_nxt = stat.viol ? PH_HALT : PH_LOADAC;
              end
            end
            PH_LOADAC, PH_POPAC: begin
              cmd.op    = acc_pkg::OP_LD_AC;
              state_nxt = S_FIN;
            end
            PH_RETPC: begin
              cmd.op    = acc_pkg::OP_LD_PC;
              state_nxt = S_FIN;
            end
            PH_IRETPC: begin
              cmd.emit  = go;
              cmd.kind  = acc_pkg::KIND_READ;
              cmd.check = 1'b1;
              cmd.asel  = acc_pkg::A_SP;
              cmd.se    = acc_pkg::SE_SP_INC;
              if (go) begin
                cmd.op    = acc_pkg::OP_LD_PC;
                state_nxt = S_WAIT;
                phase_nxt = stat.viol ? PH_HALT : PH_IRETSP;
              end
            end
            PH_IRETSP: begin
              cmd.op    = acc_pkg::OP_LD_SP_USR;
              state_nxt = S_FIN;
            end
            default: state_nxt = S_WAIT;
          endcase
        end
      end

      S_INIT: begin
        cmd.op    = acc_pkg::OP_INIT;
        state_nxt = S_TMR;
      end

      // countdown reload before each fetch
      S_TMR: begin
        cmd.op    = acc_pkg::OP_TMR;
        state_nxt = S_FCHK;
      end

      S_FCHK: begin
        if (stat.pend && !stat.kernel) begin
          sw_nxt    = 1'b0;
          state_nxt = S_INT1;
        end else begin
          state_nxt = S_FRD;
        end
      end

      // interrupt entry: push old SP, then PC, on the system stack
      S_INT1: begin
        cmd.emit = go;
        cmd.kind = acc_pkg::KIND_WRITE;
        cmd.asel = acc_pkg::A_INT1;
        cmd.dsel = acc_pkg::D_SP;
        cmd.se   = acc_pkg::SE_INT1;
        if (go) state_nxt = S_INT2;
      end

      S_INT2: begin
        cmd.emit = go;
        cmd.kind = acc_pkg::KIND_WRITE;
        cmd.asel = acc_pkg::A_INT2;
        cmd.dsel = acc_pkg::D_PC;
        cmd.se   = sw_r ? acc_pkg::SE_INT2_SW : acc_pkg::SE_INT2_TMR;
        if (go) state_nxt = sw_r ? S_FIN : S_FRD;
      end

      S_FRD: begin
        cmd.emit  = go;
        cmd.kind  = acc_pkg::KIND_READ;
        cmd.check = 1'b1;
        cmd.asel  = acc_pkg::A_PC;
        cmd.se    = acc_pkg::SE_PC_INC;
        if (go) begin
          state_nxt = S_WAIT;
          phase_nxt = stat.viol ? PH_HALT : PH_FETCH;
        end
      end

      S_FIN: begin
        cmd.op    = acc_pkg::OP_TICK;
        state_nxt = S_TMR;
      end

      S_LDIR: begin
        cmd.op    = acc_pkg::OP_LD_IR;
        state_nxt = S_EXEC;
      end

      S_RDARG: begin
        cmd.emit  = go;
        cmd.kind  = acc_pkg::KIND_READ;
        cmd.check = 1'b1;
        cmd.asel  = acc_pkg::A_PC;
        cmd.se    = acc_pkg::SE_PC_INC;
        if (go) begin
          state_nxt = S_WAIT;
          phase_nxt = stat.viol ? PH_HALT : PH_ARG;
        end
      end

      // opcode decode
      S_EXEC: begin
        state_nxt = S_FIN;
        if (stat.ir_small) begin
          case (stat.ir_op)
            OPC_LDV, OPC_LDA, OPC_LDI, OPC_LDX, OPC_LDY, OPC_ST, OPC_PUT,
            OPC_JMP: state_nxt = S_RDARG;
            OPC_JEQ, OPC_JNE: begin
              if (stat.ac_zero == (stat.ir_op == OPC_JEQ)) begin
                state_nxt = S_RDARG;
              end else begin
                cmd.op = acc_pkg::OP_PC_INC;
              end
            end
            OPC_LDSX, OPC_RET, OPC_POP, OPC_IRET: begin
              cmd.emit  = go;
              cmd.kind  = acc_pkg::KIND_READ;
              cmd.check = 1'b1;
              if (stat.ir_op == OPC_LDSX) begin
                cmd.asel = acc_pkg::A_SP_X;
              end else begin
                cmd.asel = acc_pkg::A_SP;
                cmd.se   = acc_pkg::SE_SP_INC;
              end
              state_nxt = state_r;
              if (go) begin
                state_nxt = S_WAIT;
                if (stat.viol) phase_nxt = PH_HALT;
                else if (stat.ir_op == OPC_LDSX) phase_nxt = PH_LOADAC;
                else if (stat.ir_op == OPC_RET) phase_nxt = PH_RETPC;
                else if (stat.ir_op == OPC_POP) phase_nxt = PH_POPAC;
                else phase_nxt = PH_IRETPC;
              end
            end
            OPC_CALL, OPC_PUSH: begin
              cmd.emit  = go;
              cmd.kind  = acc_pkg::KIND_WRITE;
              cmd.check = 1'b1;
              cmd.asel  = acc_pkg::A_SP_DEC;
              cmd.dsel  = (stat.ir_op == OPC_CALL) ? acc_pkg::D_PC1 : acc_pkg::D_AC;
              cmd.se    = acc_pkg::SE_SP_DEC;
              state_nxt = state_r;
              if (go) begin
                if (stat.viol) begin
                  state_nxt = S_WAIT;
                  phase_nxt = PH_HALT;
                end else begin
                  state_nxt = (stat.ir_op == OPC_CALL) ? S_RDARG : S_FIN;
                end
              end
            end
            OPC_GET:  cmd.op = acc_pkg::OP_GET;
            OPC_ADDX: cmd.op = acc_pkg::OP_ADDX;
            OPC_ADDY: cmd.op = acc_pkg::OP_ADDY;
            OPC_SUBX: cmd.op = acc_pkg::OP_SUBX;
            OPC_SUBY: cmd.op = acc_pkg::OP_SUBY;
            OPC_TOX:  cmd.op = acc_pkg::OP_AC2X;
            OPC_FRX:  cmd.op = acc_pkg::OP_X2AC;
            OPC_TOY:  cmd.op = acc_pkg::OP_AC2Y;
            OPC_FRY:  cmd.op = acc_pkg::OP_Y2AC;
            OPC_TOSP: cmd.op = acc_pkg::OP_AC2SP;
            OPC_FRSP: cmd.op = acc_pkg::OP_SP2AC;
            OPC_INCX: cmd.op = acc_pkg::OP_INCX;
            OPC_DECX: cmd.op = acc_pkg::OP_DECX;
            OPC_INT: begin
              if (!stat.kernel) begin
                sw_nxt    = 1'b1;
                state_nxt = S_INT1;
              end
            end
            OPC_END: begin
              cmd.emit  = go;
              cmd.kind  = acc_pkg::KIND_HALT;
              state_nxt = state_r;
              if (go) begin
                cmd.op    = acc_pkg::OP_HALT;
                state_nxt = S_WAIT;
                phase_nxt = PH_HALT;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // operand word has arrived
      S_ARG: begin
        state_nxt = S_FIN;
        case (stat.ir_op)
          OPC_LDV: cmd.op = acc_pkg::OP_LD_AC;
          OPC_LDA, OPC_LDI, OPC_LDX, OPC_LDY: begin
            cmd.emit  = go;
            cmd.kind  = acc_pkg::KIND_READ;
            cmd.check = 1'b1;
            if (stat.ir_op == OPC_LDX) cmd.asel = acc_pkg::A_DIN_X;
            else if (stat.ir_op == OPC_LDY) cmd.asel = acc_pkg::A_DIN_Y;
            else cmd.asel = acc_pkg::A_DIN;
            state_nxt = state_r;
            if (go) begin
              state_nxt = S_WAIT;
              if (stat.viol) phase_nxt = PH_HALT;
              else if (stat.ir_op == OPC_LDI) phase_nxt = PH_IND;
              else phase_nxt = PH_LOADAC;
            end
          end
          OPC_ST: begin
            cmd.emit  = go;
            cmd.kind  = acc_pkg::KIND_WRITE;
            cmd.check = 1'b1;
            cmd.asel  = acc_pkg::A_DIN;
            cmd.dsel  = acc_pkg::D_AC;
            state_nxt = state_r;
            if (go) begin
              if (stat.viol) begin
                state_nxt = S_WAIT;
                phase_nxt = PH_HALT;
              end else begin
                state_nxt = S_FIN;
              end
            end
          end
          OPC_PUT: begin
            cmd.emit = go;
            if (stat.din_is1) begin
              cmd.kind = acc_pkg::KIND_PUTI;
              cmd.dsel = acc_pkg::D_AC;
            end else if (stat.din_is2) begin
              cmd.kind = acc_pkg::KIND_PUTC;
              cmd.dsel = acc_pkg::D_AC8;
            end else begin
              cmd.kind = acc_pkg::KIND_BADP;
              cmd.dsel = acc_pkg::D_DIN;
            end
            state_nxt = go ? S_FIN : state_r;
          end
          default: cmd.op = acc_pkg::OP_LD_PC;
        endcase
      end

      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
      phase_r <= PH_IDLE;
      act_r   <= 1'b0;
      sw_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= (state_r == S_INIT) ? PH_IDLE : phase_nxt;
      act_r   <= act_nxt;
      sw_r    <= sw_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/acc_dp.sv -----
// Datapath of the accumulator core: architectural registers, timer
// countdown, address/data selection and the result register. Depends on acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acc_dp #(
  parameter int WORD_BITS = acc_pkg::WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire acc_pkg::acc_cmd_t  cmd,
  output acc_pkg::acc_stat_t      stat,
  input  wire logic signed [31:0] in_read_data,
  input  wire logic [6:0]         in_random_value,
  input  wire logic [15:0]        timer_interval,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic signed [31:0]      out_address,
  output logic signed [31:0]      out_data,
  output logic                    out_last
);

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] SP_USER   = W'(1000);
  localparam logic [W-1:0] SYS_LIMIT = W'(1000);
  localparam logic [W-1:0] SP_INT1   = W'(1999);
  localparam logic [W-1:0] SP_INT2   = W'(1998);
  localparam logic [W-1:0] VEC_TMR   = W'(1000);
  localparam logic [W-1:0] VEC_SW    = W'(1500);
  localparam logic [W-1:0] ONE       = W'(1);
  localparam logic [W-1:0] TWO       = W'(2);

  logic [W-1:0] pc_r, pc_nxt, sp_r, sp_nxt, ir_r, ir_nxt, ac_r, ac_nxt;
  logic [W-1:0] x_r, x_nxt, y_r, y_nxt, din_r;
  logic         kernel_r, kernel_nxt, pend_r, pend_nxt;
  logic [15:0]  cnt_r, cnt_nxt;
  logic [6:0]   rnd_r;
  logic [W-1:0] addr, data;
  logic         viol;
  logic [2:0]   kind;

  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic signed [31:0] out_addr_r, out_data_r;
  logic              out_last_r;

  // beat address and data selection
  always_comb begin
    case (cmd.asel)
      acc_pkg::A_PC:    addr = pc_r;
      acc_pkg::A_SP:    addr = sp_r;
      acc_pkg::A_SP_DEC: addr = sp_r - ONE;
      acc_pkg::A_SP_X:  addr = sp_r + x_r;
      acc_pkg::A_DIN:   addr = din_r;
      acc_pkg::A_DIN_X: addr = din_r + x_r;
      acc_pkg::A_DIN_Y: addr = din_r + y_r;
      acc_pkg::A_INT1:  addr = SP_INT1;
      acc_pkg::A_INT2:  addr = SP_INT2;
      default:          addr = '0;
    endcase
    case (cmd.dsel)
      acc_pkg::D_AC:  data = ac_r;
      acc_pkg::D_AC8: data = {{(W-8){1'b0}}, ac_r[7:0]};
      acc_pkg::D_DIN: data = din_r;
      acc_pkg::D_SP:  data = sp_r;
      acc_pkg::D_PC:  data = pc_r;
      acc_pkg::D_PC1: data = pc_r + ONE;
      default:        data = '0;
    endcase
  end

  // user access to system space
  assign viol = cmd.check && !kernel_r && !addr[W-1] && (addr >= SYS_LIMIT);
  assign kind = viol ? acc_pkg::KIND_VIOL : cmd.kind;

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.viol     = viol;
  assign stat.ac_zero  = (ac_r == '0);
  assign stat.din_is1  = (din_r == ONE);
  assign stat.din_is2  = (din_r == TWO);
  assign stat.kernel   = kernel_r;
  assign stat.pend     = pend_r;
  assign stat.ir_small = (ir_r[W-1:6] == '0);
  assign stat.ir_op    = ir_r[5:0];

  // register updates, then beat side effects
  always_comb begin
    pc_nxt = pc_r; sp_nxt = sp_r; ir_nxt = ir_r; ac_nxt = ac_r;
    x_nxt = x_r; y_nxt = y_r; kernel_nxt = kernel_r; pend_nxt = pend_r;
    cnt_nxt = cnt_r;
    case (cmd.op)
      acc_pkg::OP_INIT: begin
        pc_nxt = '0; sp_nxt = SP_USER; ir_nxt = '0; ac_nxt = '0;
        x_nxt = '0; y_nxt = '0; kernel_nxt = 1'b0; pend_nxt = 1'b0;
        cnt_nxt = timer_interval;
      end
      acc_pkg::OP_LD_IR: ir_nxt = din_r;
      acc_pkg::OP_LD_AC: ac_nxt = din_r;
      acc_pkg::OP_LD_PC: pc_nxt = din_r;
      acc_pkg::OP_LD_SP_USR: begin
        sp_nxt     = din_r;
        kernel_nxt = 1'b0;
      end
      acc_pkg::OP_PC_INC: pc_nxt = pc_r + ONE;
      acc_pkg::OP_TMR: begin
        if (cnt_r == '0) begin
          pend_nxt = 1'b1;
          cnt_nxt  = timer_interval;
        end
      end
      acc_pkg::OP_TICK: if (cnt_r != '0) cnt_nxt = cnt_r - 16'd1;
      acc_pkg::OP_HALT:  ac_nxt = '1;
      acc_pkg::OP_GET:   ac_nxt = {{(W-7){1'b0}}, rnd_r};
      acc_pkg::OP_ADDX:  ac_nxt = ac_r + x_r;
      acc_pkg::OP_ADDY:  ac_nxt = ac_r + y_r;
      acc_pkg::OP_SUBX:  ac_nxt = ac_r - x_r;
      acc_pkg::OP_SUBY:  ac_nxt = ac_r - y_r;
      acc_pkg::OP_AC2X:  x_nxt = ac_r;
      acc_pkg::OP_X2AC:  ac_nxt = x_r;
      acc_pkg::OP_AC2Y:  y_nxt = ac_r;
      acc_pkg::OP_Y2AC:  ac_nxt = y_r;
      acc_pkg::OP_AC2SP: sp_nxt = ac_r;
      acc_pkg::OP_SP2AC: ac_nxt = sp_r;
      acc_pkg::OP_INCX:  x_nxt = x_r + ONE;
      acc_pkg::OP_DECX:  x_nxt = x_r - ONE;
      default: ;
    endcase
    if (cmd.emit) begin
      case (cmd.se)
        acc_pkg::SE_PC_INC: pc_nxt = pc_r + ONE;
        acc_pkg::SE_SP_INC: sp_nxt = sp_r + ONE;
        acc_pkg::SE_SP_DEC: sp_nxt = sp_r - ONE;
        acc_pkg::SE_INT1: begin
          kernel_nxt = 1'b1;
          sp_nxt     = SP_INT1;
        end
        acc_pkg::SE_INT2_TMR: begin
          sp_nxt   = SP_INT2;
          pc_nxt   = VEC_TMR;
          pend_nxt = 1'b0;
        end
        acc_pkg::SE_INT2_SW: begin
          sp_nxt = SP_INT2;
          pc_nxt = VEC_SW;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; sp_r <= SP_USER; ir_r <= '0; ac_r <= '0;
      x_r <= '0; y_r <= '0; kernel_r <= 1'b0; pend_r <= 1'b0;
      cnt_r <= acc_pkg::TIMER_RESET;
    end else begin
      pc_r <= pc_nxt; sp_r <= sp_nxt; ir_r <= ir_nxt; ac_r <= ac_nxt;
      x_r <= x_nxt; y_r <= y_nxt; kernel_r <= kernel_nxt; pend_r <= pend_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      din_r <= W'($signed(in_read_data));
      rnd_r <= in_random_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= kind;
      out_addr_r <= 32'($signed(addr));
      out_data_r <= viol ? 32'sd0 : 32'($signed(data));
      out_last_r <= (kind == acc_pkg::KIND_READ) || (kind == acc_pkg::KIND_VIOL) ||
                    (kind == acc_pkg::KIND_HALT);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_address = out_addr_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/accumulator_cpu_core_with_timer_irq_core.sv -----
// Accumulator CPU core with timer interrupt: one input beat (start command or
// returned read word) runs the core until it needs its next read word. The
// results of a beat come out in order, writes and console puts first, then one
// read request, halt or access violation, which carries out_last. A beat is
// accepted and dispatched; an opcode word is then loaded and decoded, a
// finished instruction goes through countdown tick, reload and interrupt
// check, and each result and each interrupt push takes a state of its own.
// The single result register holds the sequencer in a state that emits while
// it is full and out_ready is low. Input is taken only while the core waits
// for a word. timer_interval sits at byte address 0 of the APB port and
// resets to 100.
// Depends on acc_pkg, acc_ctrl and acc_dp.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_cpu_core_with_timer_irq_core #(
  parameter int WORD_BITS = acc_pkg::WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic signed [31:0] in_read_data,
  input  wire logic [6:0]         in_random_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic signed [31:0]      out_address,
  output logic signed [31:0]      out_data,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  acc_pkg::acc_cmd_t  cmd;
  acc_pkg::acc_stat_t stat;
  logic [15:0]        interval_r;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, interval_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= acc_pkg::TIMER_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      interval_r <= pwdata[15:0];
    end
  end

  acc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  acc_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_read_data    (in_read_data),
    .in_random_value (in_random_value),
    .timer_interval  (interval_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_address     (out_address),
    .out_data        (out_data),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the accumulator core with timer interrupt.
// Answers the core's read requests, predicts every result beat and checks it.
// Depends on acc_pkg and accumulator_cpu_core_with_timer_irq_core.
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  // Opcodes
  localparam logic [31:0] OPC_LOAD_VAL = 32'd1, OPC_LOAD_ADDR = 32'd2, OPC_LOAD_IND = 32'd3;
  localparam logic [31:0] OPC_LOAD_IDX_X = 32'd4, OPC_LOAD_IDX_Y = 32'd5;
  localparam logic [31:0] OPC_LOAD_SP_X = 32'd6, OPC_STORE = 32'd7, OPC_GET = 32'd8;
  localparam logic [31:0] OPC_PUT = 32'd9, OPC_ADD_X = 32'd10, OPC_ADD_Y = 32'd11;
  localparam logic [31:0] OPC_SUB_X = 32'd12, OPC_SUB_Y = 32'd13, OPC_COPY_TO_X = 32'd14;
  localparam logic [31:0] OPC_COPY_FROM_X = 32'd15, OPC_COPY_TO_Y = 32'd16;
  localparam logic [31:0] OPC_COPY_FROM_Y = 32'd17, OPC_COPY_TO_SP = 32'd18;
  localparam logic [31:0] OPC_COPY_FROM_SP = 32'd19, OPC_JUMP = 32'd20, OPC_JEQ = 32'd21;
  localparam logic [31:0] OPC_JNE = 32'd22, OPC_CALL = 32'd23, OPC_RET = 32'd24;
  localparam logic [31:0] OPC_INC_X = 32'd25, OPC_DEC_X = 32'd26, OPC_PUSH = 32'd27;
  localparam logic [31:0] OPC_POP = 32'd28, OPC_INT = 32'd29, OPC_IRET = 32'd30;
  localparam logic [31:0] OPC_END = 32'd50;

  localparam logic [31:0] SYS_BASE = 32'd1000;
  localparam logic [31:0] SYS_STACK = 32'd2000;
  localparam logic [31:0] SW_VECTOR = 32'd1500;
  localparam logic [31:0] USER_STACK = 32'd1000;
  localparam logic [2:0] ADDR_TIMER = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam logic ACT_START = 1'b0, ACT_DATA = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FETCH, PH_ARG, PH_IND, PH_LOADAC, PH_RETPC, PH_IRETPC, PH_IRETSP,
    PH_POPAC, PH_HALT
  } core_phase_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [31:0] in_read_data = '0;
  logic [6:0] in_random_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_kind;
  logic signed [31:0] out_address;
  logic signed [31:0] out_data;
  logic out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  accumulator_cpu_core_with_timer_irq_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_read_data(in_read_data), .in_random_value(in_random_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_address(out_address), .out_data(out_data), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted core state
  logic [15:0] timer_interval = acc_pkg::TIMER_RESET;
  logic [31:0] pc, sp, ir, ac, ix, iy;
  logic kmode, tpend;
  logic [15:0] countdown;
  core_phase_t ph = PH_IDLE;

  result_t step_q[$];
  result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit beat_taken = 0;
  int hold_cycles = 0;
  int rx_wait = 0;
  int rx_beats = 0;
  int tx_items = 0;

  // ---------------- predictor ----------------
  function automatic void add_result(logic [2:0] k, logic [31:0] a, logic [31:0] d);
    result_t r;
    if (step_q.size() >= 4) return;
    r.kind = k; r.addr = a; r.data = d; r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic bit is_violation(logic [31:0] a);
    return !kmode && !a[31] && a >= SYS_BASE;
  endfunction

  function automatic void read_req(logic [31:0] a, core_phase_t nxt);
    if (is_violation(a)) begin
      add_result(acc_pkg::KIND_VIOL, a, '0);
      ph = PH_HALT;
    end else begin
      add_result(acc_pkg::KIND_READ, a, '0);
      ph = nxt;
    end
  endfunction

  function automatic bit write_req(logic [31:0] a, logic [31:0] v);
    if (is_violation(a)) begin
      add_result(acc_pkg::KIND_VIOL, a, '0);
      ph = PH_HALT;
      return 0;
    end
    add_result(acc_pkg::KIND_WRITE, a, v);
    return 1;
  endfunction

  function automatic bit push_word(logic [31:0] v);
    sp = sp - 1;
    return write_req(sp, v);
  endfunction

  function automatic void enter_irq(bit soft_irq);
    logic [31:0] old_sp;
    if (kmode) return;
    kmode = 1'b1;
    old_sp = sp;
    sp = SYS_STACK;
    void'(push_word(old_sp));
    void'(push_word(pc));
    if (soft_irq) begin
      pc = SW_VECTOR;
    end else begin
      tpend = 1'b0;
      pc = SYS_BASE;
    end
  endfunction

  function automatic void fetch_next();
    logic [31:0] a;
    if (countdown == 0) begin
      tpend = 1'b1;
      countdown = timer_interval;
    end
    if (tpend) enter_irq(1'b0);
    a = pc;
    pc = pc + 1;
    read_req(a, PH_FETCH);
  endfunction

  function automatic void retire();
    if (countdown > 0) countdown = countdown - 1;
    fetch_next();
  endfunction

  function automatic void read_operand();
    logic [31:0] a;
    a = pc;
    pc = pc + 1;
    read_req(a, PH_ARG);
  endfunction

  function automatic void pop_into(core_phase_t nxt);
    logic [31:0] a;
    a = sp;
    sp = sp + 1;
    read_req(a, nxt);
  endfunction

  function automatic void core_clear();
    pc = '0; sp = USER_STACK; ir = '0; ac = '0; ix = '0; iy = '0;
    kmode = 1'b0; tpend = 1'b0; countdown = timer_interval; ph = PH_IDLE;
  endfunction

  function automatic void run_opcode(logic [6:0] rnd);
    case (ir)
      OPC_LOAD_VAL, OPC_LOAD_ADDR, OPC_LOAD_IND, OPC_LOAD_IDX_X, OPC_LOAD_IDX_Y,
      OPC_STORE, OPC_PUT, OPC_JUMP: begin
        read_operand();
        return;
      end
      OPC_LOAD_SP_X: begin
        read_req(sp + ix, PH_LOADAC);
        return;
      end
      OPC_GET: ac = {25'd0, rnd};
      OPC_ADD_X: ac = ac + ix;
      OPC_ADD_Y: ac = ac + iy;
      OPC_SUB_X: ac = ac - ix;
      OPC_SUB_Y: ac = ac - iy;
      OPC_COPY_TO_X: ix = ac;
      OPC_COPY_FROM_X: ac = ix;
      OPC_COPY_TO_Y: iy = ac;
      OPC_COPY_FROM_Y: ac = iy;
      OPC_COPY_TO_SP: sp = ac;
      OPC_COPY_FROM_SP: ac = sp;
      OPC_JEQ, OPC_JNE: begin
        if ((ac == 0) == (ir == OPC_JEQ)) begin
          read_operand();
          return;
        end
        pc = pc + 1;
      end
      OPC_CALL: begin
        if (!push_word(pc + 1)) return;
        read_operand();
        return;
      end
      OPC_RET: begin
        pop_into(PH_RETPC);
        return;
      end
      OPC_INC_X: ix = ix + 1;
      OPC_DEC_X: ix = ix - 1;
      OPC_PUSH: if (!push_word(ac)) return;
      OPC_POP: begin
        pop_into(PH_POPAC);
        return;
      end
      OPC_INT: enter_irq(1'b1);
      OPC_IRET: begin
        pop_into(PH_IRETPC);
        return;
      end
      OPC_END: begin
        ac = '1;
        add_result(acc_pkg::KIND_HALT, '0, '0);
        ph = PH_HALT;
        return;
      end
      default: ;
    endcase
    retire();
  endfunction

  function automatic void use_operand(logic [31:0] d);
    case (ir)
      OPC_LOAD_VAL: ac = d;
      OPC_LOAD_ADDR: begin read_req(d, PH_LOADAC); return; end
      OPC_LOAD_IND: begin read_req(d, PH_IND); return; end
      OPC_LOAD_IDX_X: begin read_req(d + ix, PH_LOADAC); return; end
      OPC_LOAD_IDX_Y: begin read_req(d + iy, PH_LOADAC); return; end
      OPC_STORE: if (!write_req(d, ac)) return;
      OPC_PUT: begin
        if (d == 32'd1) add_result(acc_pkg::KIND_PUTI, '0, ac);
        else if (d == 32'd2) add_result(acc_pkg::KIND_PUTC, '0, {24'd0, ac[7:0]});
        else add_result(acc_pkg::KIND_BADP, '0, d);
      end
      default: pc = d;
    endcase
    retire();
  endfunction

  // Runs the model for one accepted beat and queues its results
  function automatic void predict_beat(logic act, logic [31:0] d, logic [6:0] rnd);
    step_q.delete();
    if (act == ACT_START) begin
      core_clear();
      fetch_next();
    end else begin
      case (ph)
        PH_FETCH: begin ir = d; run_opcode(rnd); end
        PH_ARG: use_operand(d);
        PH_IND: read_req(d, PH_LOADAC);
        PH_LOADAC, PH_POPAC: begin ac = d; retire(); end
        PH_RETPC: begin pc = d; retire(); end
        PH_IRETPC: begin pc = d; pop_into(PH_IRETSP); end
        PH_IRETSP: begin sp = d; kmode = 1'b0; retire(); end
        default: ;
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // ---------------- stimulus ----------------
  function automatic int draw_gap(int count);
    if ((count / 40) % 3 == 2) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_beat(input logic act, input logic [31:0] d, input logic [6:0] rnd);
    int gap;
    gap = draw_gap(tx_items);
    tx_items++;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_read_data <= d;
    in_random_value <= rnd;
    do @(posedge clk); while (!in_ready);
    predict_beat(act, d, rnd);
  endtask

  function automatic logic [31:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(0, 999);
    if (sel < 9) return $urandom_range(990, 1010);
    return $urandom();
  endfunction

  // Answers the pending read like a program would, with some noise
  task automatic send_program_beat();
    logic [31:0] d;
    logic [6:0] rnd;
    int sel;
    rnd = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 100));
    sel = $urandom_range(0, 99);
    if (ph == PH_IDLE || ph == PH_HALT) begin
      if (sel < 5) send_beat(ACT_DATA, $urandom(), rnd);
      else send_beat(ACT_START, $urandom(), rnd);
      return;
    end
    if (sel < 3) begin
      send_beat(ACT_START, $urandom(), rnd);
      return;
    end
    case (ph)
      PH_FETCH: begin
        sel = $urandom_range(0, 99);
        if (sel < 90) d = $urandom_range(1, 30);
        else if (sel < 94) d = OPC_END;
        else if (sel < 97) d = $urandom_range(0, 63);
        else d = $urandom();
      end
      PH_ARG: begin
        case (ir)
          OPC_LOAD_VAL: d = $urandom();
          OPC_PUT: d = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(1, 2);
          OPC_JUMP, OPC_JEQ, OPC_JNE, OPC_CALL:
            d = ($urandom_range(0, 19) == 0) ? pick_addr() : $urandom_range(0, 300);
          default: d = pick_addr();
        endcase
      end
      PH_IND: d = pick_addr();
      PH_RETPC, PH_IRETPC: d = $urandom_range(0, 300);
      PH_IRETSP: d = $urandom_range(900, 1000);
      default: d = $urandom();
    endcase
    if ($urandom_range(0, 49) == 0) d = $urandom();
    send_beat(ACT_DATA, d, rnd);
  endtask

  // Drop valid after the last beat, then let all results drain
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] a, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(negedge clk) penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_TIMER) timer_interval = v[15:0];
  endtask

  // ---------------- result side ----------------
  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (beat_taken) begin
      rx_beats++;
      rx_wait = draw_gap(rx_beats);
    end
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    result_t e;
    beat_taken = out_valid && out_ready;
    if ((in_valid && in_ready) || beat_taken) idle_cycles = 0;
    else idle_cycles++;
    if (beat_taken) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d addr=%0d data=%0d last=%0b", $time,
                 out_kind, out_address, out_data, out_last);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_kind !== e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, out_kind);
          errors++;
        end
        if (out_address !== e.addr) begin
          $display("%0t: address expected %0d actual %0d", $time, $signed(e.addr),
                   out_address);
          errors++;
        end
        if (out_data !== e.data) begin
          $display("%0t: data expected %0d actual %0d", $time, $signed(e.data), out_data);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $time, e.last, out_last);
          errors++;
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_beat(ACT_DATA, 32'h1234_5678, 7'd5);     // ignored while idle
    send_beat(ACT_START, '0, 7'd1);
    send_beat(ACT_DATA, OPC_LOAD_VAL, 7'd1);
    send_beat(ACT_DATA, 32'h8000_0000, 7'd1);
    send_beat(ACT_DATA, OPC_COPY_TO_X, 7'd1);
    send_beat(ACT_DATA, OPC_GET, 7'd127);         // out-of-range random value
    send_beat(ACT_DATA, OPC_PUT, 7'd1);
    send_beat(ACT_DATA, 32'd1, 7'd1);
    send_beat(ACT_DATA, OPC_GET, 7'd0);
    send_beat(ACT_DATA, OPC_PUT, 7'd100);
    send_beat(ACT_DATA, 32'd2, 7'd1);
    send_beat(ACT_DATA, OPC_PUT, 7'd1);
    send_beat(ACT_DATA, 32'h7FFF_FFFF, 7'd1);     // invalid port
    send_beat(ACT_DATA, OPC_PUSH, 7'd1);
    send_beat(ACT_DATA, OPC_INT, 7'd1);
    send_beat(ACT_DATA, OPC_IRET, 7'd1);
    send_beat(ACT_DATA, 32'd5, 7'd1);
    send_beat(ACT_DATA, 32'd990, 7'd1);
    send_beat(ACT_DATA, OPC_LOAD_ADDR, 7'd1);
    send_beat(ACT_DATA, 32'd1500, 7'd1);          // user access to system space
    send_beat(ACT_DATA, 32'hFFFF_FFFF, 7'd1);     // ignored while halted
    send_beat(ACT_START, 32'hFFFF_FFFF, 7'd64);
    send_beat(ACT_DATA, OPC_END, 7'd1);
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    repeat (n_items) send_program_beat();
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_beat(ACT_START, '0, 7'd1);
    hold_cycles = 400;
    repeat (25) send_program_beat();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    core_clear();
    test_directed();
    test_random(50);
    cfg_write(ADDR_TIMER, 32'd5);
    test_random(50);
    cfg_write(ADDR_TIMER, 32'd1);
    test_random(40);
    cfg_write(ADDR_TIMER, 32'd0);                 // zero interval
    test_random(40);
    cfg_write(ADDR_TIMER, 32'd65535);
    cfg_write(ADDR_UNUSED, 32'd7);                // no register there
    test_random(50);
    cfg_write(ADDR_TIMER, 32'd3);
    test_backpressure();
    test_random(40);
    wait_drained();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
